// ----- hdl/gppd_pkg.sv -----
`timescale 1ns / 1ps

package gppd_pkg;

    localparam logic [3:0] FRAME_LEN = 4'd9;
    localparam logic [3:0] POS_DEVICE_ID = 4'd1;
    localparam logic [3:0] POS_DIRECTION = 4'd3;
    localparam logic [3:0] POS_FACE = 4'd4;
    localparam logic [3:0] POS_STICK_X = 4'd7;
    localparam logic [3:0] POS_LAST = 4'd8;

    localparam logic [7:0] ID_ANALOG_A = 8'h73;
    localparam logic [7:0] ID_ANALOG_B = 8'h79;

    localparam logic [7:0] BTN_CROSS = 8'h40;
    localparam logic [7:0] BTN_CIRCLE = 8'h20;
    localparam logic [7:0] BTN_SQUARE = 8'h80;
    localparam logic [7:0] BTN_TRIANGLE = 8'h10;
    localparam logic [7:0] BTN_R1 = 8'h08;
    localparam logic [7:0] BTN_L1 = 8'h04;
    localparam logic [7:0] BTN_R2 = 8'h02;

    localparam logic [7:0] DIR_UP = 8'h10;
    localparam logic [7:0] DIR_DOWN = 8'h40;
    localparam logic [7:0] DIR_LEFT = 8'h80;
    localparam logic [7:0] DIR_RIGHT = 8'h20;
    localparam logic [7:0] DIR_START = 8'h08;
    localparam logic [7:0] DIR_SELECT = 8'h01;

    localparam logic [1:0] LAYOUT_RESET = 2'd2;
    localparam logic [7:0] LOW_LIMIT_RESET = 8'd40;
    localparam logic [7:0] HIGH_LIMIT_RESET = 8'd210;

    typedef enum logic [1:0] {
        CFG_BUTTON_LAYOUT = 2'd0,
        CFG_STICK_LOW_LIMIT = 2'd1,
        CFG_STICK_HIGH_LIMIT = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       frame_start;
    } gppd_in_t;

    typedef struct packed {
        logic button_one;
        logic button_two;
        logic button_three;
        logic button_four;
        logic button_five;
        logic button_six;
        logic start_pressed;
        logic coin_pressed;
        logic dir_up;
        logic dir_down;
        logic dir_left;
        logic dir_right;
    } gppd_out_t;

    typedef struct packed {
        logic [1:0] button_layout;
        logic [7:0] stick_low_limit;
        logic [7:0] stick_high_limit;
    } gppd_cfg_t;

    localparam logic [7:0] LAYOUT_MASKS [4][6] = '{
        '{BTN_CROSS, BTN_CIRCLE, BTN_R2, BTN_SQUARE, BTN_TRIANGLE, BTN_R1},
        '{BTN_SQUARE, BTN_TRIANGLE, BTN_R1, BTN_CROSS, BTN_CIRCLE, BTN_R2},
        '{BTN_CROSS, BTN_CIRCLE, BTN_SQUARE, BTN_TRIANGLE, BTN_L1, BTN_R1},
        '{BTN_SQUARE, BTN_CROSS, BTN_CIRCLE, BTN_TRIANGLE, BTN_L1, BTN_R1}
    };

    // active low: a clear bit means pressed
    function automatic logic pressed(input logic [7:0] value, input logic [7:0] mask);
        return ((value & mask) == 8'h00);
    endfunction

    // mask index 0 is button_one, which lands in result bit 5
    function automatic logic [5:0] map_buttons(input logic [7:0] face,
                                               input logic [1:0] layout);
        logic [5:0] res;
        res = '0;
        for (int i = 0; i < 6; i++) begin
            res[5 - i] = pressed(face, LAYOUT_MASKS[layout][i]);
        end
        return res;
    endfunction

endpackage

// ----- hdl/game_pad_poll_response_decoder_top.sv -----
`timescale 1ns / 1ps

// Decodes a game pad poll response arriving one byte per request, first byte flagged by
// frame_start; the ninth byte of a frame yields one result with mapped buttons and
// directions, other bytes yield none. Throughput is one byte per cycle: a byte is held in
// the input register and its result is then registered in the output register. The input
// side stalls only when a ninth byte sits in the input register while the previous result
// has not been taken. Configuration writes take effect at once and should be made while
// no byte is in flight.
module game_pad_poll_response_decoder_top import gppd_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  gppd_in_t   s_data,
    output logic       m_valid,
    input  logic       m_ready,
    output gppd_out_t  m_data,
    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_wdata
);

    logic      s1_valid_reg;
    gppd_in_t  s1_data_reg;
    logic      m_valid_reg;
    gppd_out_t m_data_reg;
    gppd_cfg_t cfg_reg;
    logic      hit;
    gppd_out_t result;
    logic      out_free;
    logic      s1_fire;

    assign out_free = !m_valid_reg || m_ready;
    assign s1_fire = s1_valid_reg && (!hit || out_free);
    assign s_ready = !s1_valid_reg || s1_fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.button_layout <= LAYOUT_RESET;
            cfg_reg.stick_low_limit <= LOW_LIMIT_RESET;
            cfg_reg.stick_high_limit <= HIGH_LIMIT_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_BUTTON_LAYOUT:    cfg_reg.button_layout <= cfg_wdata[1:0];
                CFG_STICK_LOW_LIMIT:  cfg_reg.stick_low_limit <= cfg_wdata;
                CFG_STICK_HIGH_LIMIT: cfg_reg.stick_high_limit <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_ready) begin
            s1_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            s1_data_reg <= s_data;
        end
    end

    gppd_frame_decoder u_decoder (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (s1_fire),
        .item    (s1_data_reg),
        .cfg     (cfg_reg),
        .hit     (hit),
        .result  (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_free) begin
            m_valid_reg <= s1_fire && hit;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_fire && hit) begin
            m_data_reg <= result;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data = m_data_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(s1_fire && hit))
        else $error("result appeared without a last byte");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_ready && s1_valid_reg && hit |-> !s1_fire && !s_ready)
        else $error("pending result would be overwritten");

    assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg && !hit |-> s1_fire)
        else $error("byte without result stalled");

endmodule

// ----- hdl/gppd_frame_decoder.sv -----
`timescale 1ns / 1ps

module gppd_frame_decoder import gppd_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      step,
    input  gppd_in_t  item,
    input  gppd_cfg_t cfg,
    output logic      hit,
    output gppd_out_t result
);

    logic [3:0] pos_reg;
    logic [3:0] pos_next;
    logic [7:0] device_id_reg;
    logic [7:0] direction_reg;
    logic [7:0] face_reg;
    logic [7:0] stick_x_reg;
    logic [3:0] pos_eff;
    logic       active;
    logic       analog;
    logic [5:0] buttons;

    assign pos_eff = item.frame_start ? 4'd0 : pos_reg;
    assign active = (pos_eff < FRAME_LEN);
    assign hit = (pos_eff == POS_LAST);
    assign pos_next = (step && active) ? pos_eff + 4'd1 : pos_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= FRAME_LEN;
            device_id_reg <= '0;
            direction_reg <= '0;
            face_reg <= '0;
            stick_x_reg <= '0;
        end else begin
            pos_reg <= pos_next;
            if (step && active) begin
                case (pos_eff)
                    POS_DEVICE_ID: device_id_reg <= item.rx_byte;
                    POS_DIRECTION: direction_reg <= item.rx_byte;
                    POS_FACE:      face_reg <= item.rx_byte;
                    POS_STICK_X:   stick_x_reg <= item.rx_byte;
                    default: ;
                endcase
            end
        end
    end

    assign analog = (device_id_reg == ID_ANALOG_A) || (device_id_reg == ID_ANALOG_B);
    assign buttons = map_buttons(face_reg, cfg.button_layout);

    // rx_byte is stick y on the last byte
    always_comb begin
        result.button_one = buttons[5];
        result.button_two = buttons[4];
        result.button_three = buttons[3];
        result.button_four = buttons[2];
        result.button_five = buttons[1];
        result.button_six = buttons[0];
        result.start_pressed = pressed(direction_reg, DIR_START);
        result.coin_pressed = pressed(direction_reg, DIR_SELECT);
        result.dir_up = pressed(direction_reg, DIR_UP)
            || (analog && (item.rx_byte < cfg.stick_low_limit));
        result.dir_down = pressed(direction_reg, DIR_DOWN)
            || (analog && (item.rx_byte > cfg.stick_high_limit));
        result.dir_left = pressed(direction_reg, DIR_LEFT)
            || (analog && (stick_x_reg < cfg.stick_low_limit));
        result.dir_right = pressed(direction_reg, DIR_RIGHT)
            || (analog && (stick_x_reg > cfg.stick_high_limit));
    end

    assert property (@(posedge aclk) disable iff (!aresetn) pos_reg <= FRAME_LEN)
        else $error("byte position out of range");

    assert property (@(posedge aclk) disable iff (!aresetn) step && hit |=> pos_reg == FRAME_LEN)
        else $error("frame not closed after last byte");

    assert property (@(posedge aclk) disable iff (!aresetn)
        step && item.frame_start |=> pos_reg == 4'd1)
        else $error("frame start did not restart position");

endmodule
